FILE: hdl/multichannel_sliding_median_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel sliding median
// Shared wrappers so that every concurrent check reports in the same way.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SLIDING_MEDIAN_ASSERT_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_ASSERT_SVH

// clocked check, switched off while reset is asserted
`define MSM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also runs through reset
`define MSM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared constants and types of the multichannel sliding median.
// ----------------------------------------------------------------------------
package msm_pkg;

    // fixed field widths
    localparam int CHANNEL_W    = 2;
    localparam int WIN_REG_W    = 6;
    // window length after reset (clipped to the build's maximum)
    localparam int WINDOW_RESET = 5;

    // control part of a command passed from front to back
    typedef struct packed {
        logic                 in_range;
        logic [CHANNEL_W-1:0] channel;
    } cmd_ctl_t;

endpackage

FILE: hdl/msm_front.sv
// ----------------------------------------------------------------------------
// msm_front
// Accepts samples, holds the window length and per-channel ring state, and
// turns each transfer into a command for the back end.
// ----------------------------------------------------------------------------
module msm_front #(
    parameter int CHANNELS    = 4,
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int IDX_W      = $clog2(MAX_WINDOW)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [msm_pkg::WIN_REG_W-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [msm_pkg::CHANNEL_W-1:0]     s_channel,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output msm_pkg::cmd_ctl_t                 cmd_ctl,
    output logic signed [SAMPLE_BITS-1:0]     cmd_sample,
    output logic [IDX_W-1:0]                  cmd_wi,
    output logic [CNT_W-1:0]                  cmd_cnt
);
    import msm_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WS_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic [IDX_W-1:0]    wi_reg [CHANNELS];
    logic [CNT_W-1:0]    cnt_reg [CHANNELS];
    logic [CNT_W-1:0]    ws_reg;

    logic                in_range;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [IDX_W-1:0]    wi_cur;
    logic [IDX_W-1:0]    wi_use;
    logic [CNT_W-1:0]    wi_inc;
    logic [IDX_W-1:0]    wi_next;
    logic [CNT_W-1:0]    cnt_cur;
    logic [CNT_W-1:0]    cnt_next;
    logic                cfg_ok;
    logic                accept;

    // classify the incoming transfer
    assign in_range = int'(s_channel) < CHANNELS;
    assign ch_idx   = CH_IDX_W'(s_channel);
    assign wi_cur   = wi_reg[ch_idx];
    assign cnt_cur  = cnt_reg[ch_idx];

    // ring index and fill count after this sample
    assign wi_use   = (CNT_W'(wi_cur) >= ws_reg) ? '0 : wi_cur;
    assign wi_inc   = CNT_W'(wi_use) + CNT_W'(1);
    assign wi_next  = (wi_inc == ws_reg) ? '0 : IDX_W'(wi_inc);
    assign cnt_next = (cnt_cur < ws_reg) ? cnt_cur + CNT_W'(1) : cnt_cur;

    // window length writes outside 1..MAX_WINDOW are dropped
    assign cfg_ok = cfg_wr_en && (cfg_wr_data != '0) && (int'(cfg_wr_data) <= MAX_WINDOW);

    assign s_ready    = cmd_ready;
    assign accept     = s_valid && s_ready;
    assign cmd_valid  = s_valid;
    assign cmd_ctl    = '{in_range: in_range, channel: s_channel};
    assign cmd_sample = s_sample;
    assign cmd_wi     = wi_use;
    assign cmd_cnt    = cnt_next;

    // window length and per-channel ring state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg <= CNT_W'(WS_RESET);
            for (int c = 0; c < CHANNELS; c++) begin
                wi_reg[c]  <= '0;
                cnt_reg[c] <= '0;
            end
        end else if (cfg_ok) begin
            ws_reg <= CNT_W'(cfg_wr_data);
            for (int c = 0; c < CHANNELS; c++) begin
                wi_reg[c]  <= '0;
                cnt_reg[c] <= '0;
            end
        end else if (accept && in_range) begin
            wi_reg[ch_idx]  <= wi_next;
            cnt_reg[ch_idx] <= cnt_next;
        end
    end

endmodule

FILE: hdl/msm_queue.sv
// ----------------------------------------------------------------------------
// msm_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module msm_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    logic [W-1:0] slot_reg [2];
    logic [1:0]   count_reg;
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // occupancy and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: hdl/msm_sorter.sv
// ----------------------------------------------------------------------------
// msm_sorter
// Row of insertion cells. Preset fills the low cells with minus-infinity
// markers and the rest with plus-infinity, so that after the window has been
// inserted the middle values always sit in the top two cells.
// ----------------------------------------------------------------------------
module msm_sorter #(
    parameter int SAMPLE_BITS = 16,
    parameter int CELLS       = 17,
    localparam int PL_W       = $clog2(CELLS + 1)
) (
    input  logic                          aclk,
    input  logic                          preset,
    input  logic [PL_W-1:0]               preset_low,
    input  logic                          ins_en,
    input  logic signed [SAMPLE_BITS-1:0] ins_value,
    output logic signed [SAMPLE_BITS-1:0] mid_lo,
    output logic signed [SAMPLE_BITS-1:0] mid_hi
);
    // cell contents
    localparam logic [1:0] CELL_LO   = 2'd0;
    localparam logic [1:0] CELL_REAL = 2'd1;
    localparam logic [1:0] CELL_HI   = 2'd2;

    logic [1:0]                   kind_reg [CELLS];
    logic signed [SAMPLE_BITS-1:0] val_reg [CELLS];
    logic [1:0]                   kind_next [CELLS];
    logic signed [SAMPLE_BITS-1:0] val_next [CELLS];
    logic [CELLS-1:0]             gt;

    // which cells hold something above the new value
    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            gt[i] = (kind_reg[i] == CELL_HI) ||
                    ((kind_reg[i] == CELL_REAL) && (val_reg[i] > ins_value));
        end
    end

    // preset or shift-and-insert
    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            kind_next[i] = kind_reg[i];
            val_next[i]  = val_reg[i];
            if (preset) begin
                kind_next[i] = (i < int'(preset_low)) ? CELL_LO : CELL_HI;
            end else if (ins_en && gt[i]) begin
                kind_next[i] = CELL_REAL;
                val_next[i]  = ins_value;
            end
        end
        // a cell above the insertion point takes its lower neighbour
        for (int i = 1; i < CELLS; i++) begin
            if (!preset && ins_en && gt[i] && gt[i-1]) begin
                kind_next[i] = kind_reg[i-1];
                val_next[i]  = val_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CELLS; i++) begin
            kind_reg[i] <= kind_next[i];
            val_reg[i]  <= val_next[i];
        end
    end

    assign mid_lo = val_reg[CELLS-2];
    assign mid_hi = val_reg[CELLS-1];

endmodule

FILE: hdl/msm_back.sv
// ----------------------------------------------------------------------------
// msm_back
// Executes commands: writes an in-range sample into the window store, streams
// its channel's window through the insertion row and registers the median.
// ----------------------------------------------------------------------------
module msm_back #(
    parameter int CHANNELS    = 4,
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
    localparam int IDX_W      = $clog2(MAX_WINDOW)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  msm_pkg::cmd_ctl_t                 cmd_ctl,
    input  logic signed [SAMPLE_BITS-1:0]     cmd_sample,
    input  logic [IDX_W-1:0]                  cmd_wi,
    input  logic [CNT_W-1:0]                  cmd_cnt,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [msm_pkg::CHANNEL_W-1:0]     m_channel,
    output logic signed [SAMPLE_BITS-1:0]     m_median
);
    import msm_pkg::*;

    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MID    = (MAX_WINDOW - 1) / 2;
    localparam int CELLS  = MID + 2;
    localparam int PL_W   = $clog2(CELLS + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    state_reg, state_next;
    cmd_ctl_t                      ctl_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]              wi_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ADDR_W-1:0]             base_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic                          rd_valid_reg;
    logic                          rd_sub_reg;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic                          out_valid_reg;
    logic [CHANNEL_W-1:0]          out_channel_reg;
    logic signed [SAMPLE_BITS-1:0] out_median_reg;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    logic                          take;
    logic [ADDR_W-1:0]             cmd_base;
    logic [CNT_W-1:0]              k_low;
    logic [PL_W-1:0]               preset_low;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          last_rd;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] mid_lo, mid_hi, ins_value;
    logic signed [SAMPLE_BITS:0]   mid_sum;
    logic signed [SAMPLE_BITS-1:0] median;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign cmd_base  = ADDR_W'(cmd_ctl.channel) * ADDR_W'(MAX_WINDOW);

    // low cells get minus-infinity so the lower middle value lands in cell MID
    assign k_low      = (cmd_cnt - CNT_W'(1)) >> 1;
    assign preset_low = PL_W'(CNT_W'(MID) - k_low);

    assign rd_addr  = base_reg + ADDR_W'(rd_idx_reg);
    assign last_rd  = (CNT_W'(rd_idx_reg) == cnt_reg - CNT_W'(1));
    assign out_free = !out_valid_reg || m_ready;

    // window store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (take && cmd_ctl.in_range) begin
            mem[cmd_base + ADDR_W'(cmd_wi)] <= cmd_sample;
        end
        rdata_reg <= mem[rd_addr];
    end

    // the slot just overwritten is taken from the command itself
    assign ins_value = rd_sub_reg ? sample_reg : rdata_reg;

    msm_sorter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CELLS       (CELLS)
    ) u_sorter (
        .aclk       (aclk),
        .preset     (take),
        .preset_low (preset_low),
        .ins_en     (rd_valid_reg),
        .ins_value  (ins_value),
        .mid_lo     (mid_lo),
        .mid_hi     (mid_hi)
    );

    // median: middle cell, or floor of the mean of the two middle cells
    assign mid_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
    always_comb begin
        if (!ctl_reg.in_range) begin
            median = '0;
        end else if (cnt_reg[0]) begin
            median = mid_lo;
        end else begin
            median = mid_sum[SAMPLE_BITS:1];
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = cmd_ctl.in_range ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                if (last_rd) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_READ);
            if ((state_reg == ST_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command and datapath registers
    always_ff @(posedge aclk) begin
        if (take) begin
            ctl_reg    <= cmd_ctl;
            sample_reg <= cmd_sample;
            wi_reg     <= cmd_wi;
            cnt_reg    <= cmd_cnt;
            base_reg   <= cmd_base;
            rd_idx_reg <= '0;
        end else if (state_reg == ST_READ) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
        rd_sub_reg <= (rd_idx_reg == wi_reg);
        if ((state_reg == ST_DONE) && out_free) begin
            out_channel_reg <= ctl_reg.channel;
            out_median_reg  <= median;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_channel = out_channel_reg;
    assign m_median  = out_median_reg;

endmodule

FILE: hdl/multichannel_sliding_median.sv
// ----------------------------------------------------------------------------
// multichannel_sliding_median
// Per-channel sliding-window median over signed samples.
//
//   channel   dir  handshake          payload (tdata, low bit first)
//   s_        in   s_tvalid/s_tready  channel, sample, zero pad
//   m_        out  m_tvalid/m_tready  channel_out, median, zero pad
//   cfg_      in   cfg_wr_en          window_size (cfg_wr_data)
//
// An in-range sample makes the back end read n window entries, n being the
// fill count after the sample: one entry is read per cycle from the window
// store into the insertion row. A sample for a channel beyond CHANNELS skips
// the read pass and gives a zero median.
// Reset is synchronous; the window store needs no clearing pass.
// A two-entry command queue and the output register let input and output
// stall independently.
// ----------------------------------------------------------------------------
module multichannel_sliding_median #(
    parameter int CHANNELS    = 4,
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int TDATA_W    = ((msm_pkg::CHANNEL_W + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [msm_pkg::WIN_REG_W-1:0] cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,   // channel, sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata    // channel_out, median
);
    import msm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CMD_W = $bits(cmd_ctl_t) + SAMPLE_BITS + IDX_W + CNT_W;

    logic                          f_valid, f_ready;
    cmd_ctl_t                      f_ctl, b_ctl;
    logic signed [SAMPLE_BITS-1:0] f_sample, b_sample;
    logic [IDX_W-1:0]              f_wi, b_wi;
    logic [CNT_W-1:0]              f_cnt, b_cnt;
    logic                          b_valid, b_ready;
    logic [CMD_W-1:0]              q_out;
    logic [CHANNEL_W-1:0]          out_channel;
    logic signed [SAMPLE_BITS-1:0] out_median;

    msm_front #(
        .CHANNELS    (CHANNELS),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_channel   (s_tdata[CHANNEL_W-1:0]),
        .s_sample    (s_tdata[CHANNEL_W +: SAMPLE_BITS]),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd_ctl     (f_ctl),
        .cmd_sample  (f_sample),
        .cmd_wi      (f_wi),
        .cmd_cnt     (f_cnt)
    );

    msm_queue #(
        .W (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_sample, f_wi, f_cnt}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    // unpack the queued command
    assign {b_ctl, b_sample, b_wi, b_cnt} = q_out;

    msm_back #(
        .CHANNELS    (CHANNELS),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd_ctl    (b_ctl),
        .cmd_sample (b_sample),
        .cmd_wi     (b_wi),
        .cmd_cnt    (b_cnt),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_channel  (out_channel),
        .m_median   (out_median)
    );

    assign m_tdata = TDATA_W'({out_median, out_channel});

endmodule

FILE: hdl/msm_checker.sv
// ----------------------------------------------------------------------------
// msm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_sliding_median_assert.svh"

module msm_checker #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 16,
    localparam int TDATA_W    = ((msm_pkg::CHANNEL_W + SAMPLE_BITS + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);
    import msm_pkg::*;

    // a stalled result stays offered
    `MSM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `MSM_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

    // channels without a window report a zero median
    `MSM_ASSERT(a_unused_zero, aclk, aresetn, m_tvalid && (int'(m_tdata[CHANNEL_W-1:0]) >= CHANNELS) |-> (m_tdata[CHANNEL_W +: SAMPLE_BITS] == '0), "non-zero median for an unused channel")

    // nothing is offered in the cycle after reset
    `MSM_ASSERT_NR(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result offered straight after reset")

endmodule

bind multichannel_sliding_median msm_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_msm_checker (.*);

FILE: tb/multichannel_sliding_median_test.sv
// ----------------------------------------------------------------------------
// multichannel_sliding_median_test
// Self-checking bench for the per-channel sliding median. A tracker class keeps
// its own copy of every channel's ring, write position and fill count, works
// out the median for each sample transfer and checks the medians that come
// back, in order. The window length is changed between phases (ignored values
// included), the sender runs in bursts and the receiver stalls on a pattern
// of its own, with two long holds that back the block up to its input.
// ----------------------------------------------------------------------------
module multichannel_sliding_median_test;
    import msm_pkg::*;

    localparam int CHANNELS    = 4;
    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int TDATA_W     = ((CHANNEL_W + SAMPLE_BITS + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - CHANNEL_W - SAMPLE_BITS;
    localparam int unsigned CYCLE_LIMIT = 800_000;
    localparam int unsigned HOLD_CYCLES = 500;
    localparam int unsigned SETTLE      = 40;

    // window lengths per phase: extremes, ignored writes (0, 33, 63), a rewrite
    localparam int unsigned WINDOW_PLAN [14] = '{1, 32, 2, 0, 7, 63, 5, 5, 33, 3, 32,
                                                 16, 4, 9};

    // opening transfers {channel, sample}, run with the reset window of 5
    localparam logic [17:0] OPENING [19] = '{
        {2'd0, 16'h8000}, {2'd0, 16'h7fff}, {2'd0, 16'h0000}, {2'd0, 16'hffff},
        {2'd0, 16'h0001}, {2'd0, 16'h7fff}, {2'd0, 16'h8000},
        {2'd1, 16'h7fff}, {2'd1, 16'h7fff},
        {2'd2, 16'h8000}, {2'd2, 16'h8000},
        {2'd3, 16'hffff}, {2'd3, 16'h0000}, {2'd3, 16'h0002}, {2'd3, 16'h0005},
        {2'd3, 16'h5555}, {2'd3, 16'haaaa},
        {2'd1, 16'h0003}, {2'd2, 16'h7fff}
    };

    typedef struct packed {
        logic [CHANNEL_W-1:0]          channel;
        logic signed [SAMPLE_BITS-1:0] median;
    } median_t;

    // ------------------------------------------------------------------------
    // Median tracker: per-channel window state and the medians still due
    // ------------------------------------------------------------------------
    class median_tracker;
        bit signed [SAMPLE_BITS-1:0] ring [CHANNELS][MAX_WINDOW];
        int unsigned wr_pos [CHANNELS];
        int unsigned fill [CHANNELS];
        int unsigned win_len = WINDOW_RESET;
        median_t     due [$];
        int unsigned errors;
        int unsigned checked;

        // only 1..MAX_WINDOW takes effect; a good write restarts every channel
        function void set_window(logic [WIN_REG_W-1:0] value);
            if (value != 0 && value <= MAX_WINDOW) begin
                win_len = int'(value);
                foreach (wr_pos[c]) begin
                    wr_pos[c] = 0;
                    fill[c]   = 0;
                end
            end
        endfunction

        // sort the filled part of the ring; even count takes the floored mean
        function logic signed [SAMPLE_BITS-1:0] middle_of_window(int unsigned ch);
            bit signed [SAMPLE_BITS-1:0] row [$];
            bit signed [SAMPLE_BITS-1:0] v;
            bit signed [SAMPLE_BITS:0]   total;
            int unsigned n;
            int unsigned j;
            n = fill[ch];
            if (n == 0)
                return '0;
            for (int unsigned i = 0; i < n; i++) begin
                v = ring[ch][i];
                j = row.size();
                row.push_back(v);
                while (j > 0 && row[j-1] > v) begin
                    row[j] = row[j-1];
                    j--;
                end
                row[j] = v;
            end
            if (n % 2 == 1)
                return row[n/2];
            total = (SAMPLE_BITS+1)'(row[n/2-1]) + (SAMPLE_BITS+1)'(row[n/2]);
            return total[SAMPLE_BITS:1];
        endfunction

        function void take_sample(logic [CHANNEL_W-1:0] ch, logic [SAMPLE_BITS-1:0] smp);
            median_t m;
            ring[ch][wr_pos[ch]] = smp;
            wr_pos[ch] = (wr_pos[ch] + 1) % win_len;
            if (fill[ch] < win_len)
                fill[ch]++;
            m.channel = ch;
            m.median  = middle_of_window(ch);
            due.push_back(m);
        endfunction

        function void check_median(logic [TDATA_W-1:0] word);
            median_t want;
            if (due.size() == 0) begin
                $display("%0t: median with none due, expected nothing, got ch %0d med %0d",
                         $time, word[CHANNEL_W-1:0],
                         $signed(word[CHANNEL_W +: SAMPLE_BITS]));
                errors++;
                return;
            end
            want = due.pop_front();
            checked++;
            if (word[CHANNEL_W-1:0] !== want.channel) begin
                $display("%0t: channel_out mismatch, expected %0d, got %0d",
                         $time, want.channel, word[CHANNEL_W-1:0]);
                errors++;
            end
            if (word[CHANNEL_W +: SAMPLE_BITS] !== want.median) begin
                $display("%0t: median mismatch on ch %0d, expected %0d, got %0d",
                         $time, want.channel, want.median,
                         $signed(word[CHANNEL_W +: SAMPLE_BITS]));
                errors++;
            end
            if (word[TDATA_W-1 -: PAD_W] !== '0) begin
                $display("%0t: tdata padding mismatch, expected %0h, got %0h",
                         $time, {PAD_W{1'b0}}, word[TDATA_W-1 -: PAD_W]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction
    endclass

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [WIN_REG_W-1:0]  cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata     = '0;   // channel, sample, zero pad
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;            // channel_out, median, zero pad

    median_tracker         tracker;
    bit                    offering;
    int unsigned           burst_left;
    logic [SAMPLE_BITS-1:0] cluster_base;
    int unsigned           sent;
    int unsigned           settings_used;
    int unsigned           cycle_count;

    multichannel_sliding_median #(
        .CHANNELS    (CHANNELS),
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic stop_offering();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic idle(input int unsigned cycles);
        stop_offering();
        repeat (cycles) @(posedge aclk);
    endtask

    // offer one sample and hold it until the transfer
    task automatic send_sample(input logic [CHANNEL_W-1:0] ch,
                               input logic [SAMPLE_BITS-1:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, smp, ch};
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.take_sample(ch, smp);
        sent++;
    endtask

    // bursts of random length, mostly with a gap after each
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
                idle(gap);
        end
    endtask

    // mix of full-range noise, corners and tight clusters (for ties)
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return SAMPLE_BITS'($urandom);
        if (roll < 45) begin
            case ($urandom_range(0, 4))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'h0000;
                3:       return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        if (roll < 85)
            return cluster_base + SAMPLE_BITS'($urandom_range(0, 15)) - 16'd8;
        if (roll < 93)
            return 16'h8000 + SAMPLE_BITS'($urandom_range(0, 3));
        return 16'h7fff - SAMPLE_BITS'($urandom_range(0, 3));
    endfunction

    // window write, only once every median is back and the back end is quiet
    task automatic write_window(input int unsigned value);
        stop_offering();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[WIN_REG_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_window(value[WIN_REG_W-1:0]);
        settings_used++;
    endtask

    // random samples, often staying on one channel for a run
    task automatic run_phase(input int unsigned items);
        logic [CHANNEL_W-1:0] ch;
        ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
        cluster_base = SAMPLE_BITS'($urandom);
        for (int unsigned n = 0; n < items; n++) begin
            if ($urandom_range(0, 9) < 6)
                ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
            send_sample(ch, pick_sample());
            pace();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall modes, plus two long holds to fill the block
    // ------------------------------------------------------------------------
    initial begin : median_sink
        int unsigned stall_mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned holds_done;
        int unsigned tick;
        stall_mode = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        tick       = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                tracker.check_median(m_tdata);
            tick++;
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 200);
            end else begin
                mode_left--;
            end
            if (hold_left == 0 && holds_done < 2 && tracker.checked >= 300 + 600 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 7 < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        tracker = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners, ties and even-count rounding with the reset window
        settings_used = 1;
        foreach (OPENING[i])
            send_sample(OPENING[i][17:16], OPENING[i][15:0]);
        idle(3);

        foreach (WINDOW_PLAN[p]) begin
            write_window(WINDOW_PLAN[p]);
            run_phase(32 + 4 * tracker.win_len);
        end
        repeat (2) begin
            write_window($urandom_range(1, MAX_WINDOW));
            run_phase(32 + 4 * tracker.win_len);
        end

        stop_offering();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (2 * SETTLE) @(posedge aclk);

        $display("Covered %0d sample transfers and %0d medians over %0d window settings,",
                 sent, tracker.checked, settings_used);
        $display("lengths 1 to 32 with ignored writes, bursty input and long output holds.");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
